@@ hw/rtl/pwtt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending wait timeout table package
// Shared types, command and result codes, and table sizing.
// ----------------------------------------------------------------------------
package pwtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int HITS_W      = $clog2(MAX_RESULTS + 1);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_REMOVE    = 3'd1;
  localparam logic [2:0] CMD_TICK      = 3'd2;
  localparam logic [2:0] CMD_CONN_LOST = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  localparam logic [1:0] KIND_TIME = 2'd0;
  localparam logic [1:0] KIND_CONN = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  localparam logic REG_REPORT_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    MODE_TIME   = 2'd0,
    MODE_CONN   = 2'd1,
    MODE_REMOVE = 2'd2
  } sweep_mode_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] conn_id;
    logic [31:0] wait_reason;
    logic [15:0] instance_tag;
    logic [15:0] packet_tag;
    logic [47:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_conn_id;
    logic [31:0] out_reason;
    logic [15:0] out_instance_tag;
    logic [15:0] out_packet_tag;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] conn;
    logic [31:0] reason;
    logic [15:0] inst;
    logic [15:0] packet;
    logic [47:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/pwtt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/pwtt_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending wait match unit
// Shared compare that decides whether one table entry is hit by a sweep.
// ----------------------------------------------------------------------------
module pwtt_match (
  input  pwtt_pkg::sweep_mode_t mode,
  input  pwtt_pkg::in_item_t    key,
  input  pwtt_pkg::entry_t      ent,
  output logic                  hit
);
  import pwtt_pkg::*;

  always_comb begin
    case (mode)
      MODE_TIME:   hit = key.time_ms > ent.expiry;
      MODE_CONN:   hit = ent.conn == key.conn_id;
      MODE_REMOVE: hit = (ent.conn == key.conn_id) && (ent.reason == key.wait_reason) &&
                         (ent.inst == key.instance_tag);
      default:     hit = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/pending_wait_timeout_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending wait timeout table
// Insertion-ordered table of pending waits with add, remove, tick expiry,
// connection loss and clear operations, swept one entry at a time.
// ----------------------------------------------------------------------------
//  Channel  Ports                                    Direction  Transaction
//  in       in_valid, in_ready, in_data              input      one command
//  out      out_valid, out_ready, out_data           output     one report
//  config   psel, penable, pwrite, paddr, pwdata,    APB slave  one register
//           prdata, pready
//
//  Add, clear, ignored commands and ticks with reporting off complete in idle; an
//  add to a full table goes on to the reject state. Remove, tick and connection
//  loss sweep the table through one RAM read port and one compare unit, reading
//  and then evaluating each stored entry in turn before a final flush.
//  A report waits in the output register while out_ready is low, stalling the sweep.
//  Reset is synchronous and empties the table through its fill count at once.
// ----------------------------------------------------------------------------
module pending_wait_timeout_table_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pwtt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pwtt_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwtt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pwtt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pwtt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import pwtt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_FLUSH  = 5'b01000,
    S_REJECT = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  sweep_mode_t mode_r, mode_nxt;
  in_item_t    item_r, item_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  wr_r, wr_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt;
  out_item_t   hold_r, hold_nxt;
  logic        hold_valid_r, hold_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        report_enable_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             hit;
  logic             hit_eff;
  logic             out_free;
  logic             in_fire;
  logic             cfg_write;
  logic [1:0]       hit_kind;

  pwtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  pwtt_match u_match (
    .mode(mode_r),
    .key (item_r),
    .ent (ram_rdata),
    .hit (hit)
  );

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_REPORT_ENABLE) ?
                     {{(CFG_DATA_W-1){1'b0}}, report_enable_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_enable_r <= 1'b0;
    end else if (cfg_write && (paddr[2] == REG_REPORT_ENABLE)) begin
      report_enable_r <= pwdata[0];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign hit_eff   = hit && ((mode_r == MODE_REMOVE) || (hits_r < HITS_W'(MAX_RESULTS)));
  assign hit_kind  = (mode_r == MODE_CONN) ? KIND_CONN : KIND_TIME;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    item_nxt       = item_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    hits_nxt       = hits_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_we         = 1'b0;
    ram_waddr      = wr_r[IDX_W-1:0];
    ram_wdata      = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt       = in_data;
          idx_nxt        = '0;
          wr_nxt         = '0;
          hits_nxt       = '0;
          hold_valid_nxt = 1'b0;
          case (in_data.cmd)
            CMD_ADD: begin
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                state_nxt = S_REJECT;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[IDX_W-1:0];
                ram_wdata = '{conn: in_data.conn_id, reason: in_data.wait_reason,
                              inst: in_data.instance_tag, packet: in_data.packet_tag,
                              expiry: in_data.time_ms};
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              mode_nxt  = MODE_REMOVE;
              state_nxt = S_READ;
            end
            CMD_TICK: begin
              if (report_enable_r) begin
                mode_nxt  = MODE_TIME;
                state_nxt = S_READ;
              end
            end
            CMD_CONN_LOST: begin
              mode_nxt  = MODE_CONN;
              state_nxt = S_READ;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = wr_r;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (hit_eff && (mode_r != MODE_REMOVE)) begin
          if (!hold_valid_r || out_free) begin
            if (hold_valid_r) begin
              out_nxt       = hold_r;
              out_valid_nxt = 1'b1;
            end
            hold_nxt       = '{kind: hit_kind, out_conn_id: ram_rdata.conn,
                               out_reason: ram_rdata.reason,
                               out_instance_tag: ram_rdata.inst,
                               out_packet_tag: ram_rdata.packet, last: 1'b0};
            hold_valid_nxt = 1'b1;
            hits_nxt       = hits_r + HITS_W'(1);
            idx_nxt        = idx_r + CNT_W'(1);
            state_nxt      = S_READ;
          end
        end else if (hit_eff) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_READ;
        end else begin
          ram_we    = 1'b1;
          wr_nxt    = wr_r + CNT_W'(1);
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt        = hold_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_REJECT: begin
        if (out_free) begin
          out_nxt       = '{kind: KIND_FULL, out_conn_id: item_r.conn_id,
                            out_reason: item_r.wait_reason,
                            out_instance_tag: item_r.instance_tag,
                            out_packet_tag: item_r.packet_tag, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_TIME;
      cnt_r        <= '0;
      idx_r        <= '0;
      wr_r         <= '0;
      hits_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      wr_r         <= wr_nxt;
      hits_r       <= hits_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("Table fill count exceeds the table depth.");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= idx_r)
    else $error("Compaction write index ran ahead of the read index.");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_valid_r)
    else $error("A held report remains after the transaction completed.");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.cmd == CMD_ADD) && (cnt_r != CNT_W'(TABLE_DEPTH)))
      |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("An accepted add did not grow the table.");
`endif

endmodule
